// File: rtl/ple_pkg.sv
package ple_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0] t_count;
    typedef logic [IDX_W-1:0] t_index;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_APPEND = 3'd1,
        REQ_READ   = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LOWER = 2'd2,
        CELL_FROM_UPPER = 2'd3
    } t_cell_op;

endpackage

// File: rtl/ple_cell.sv
module ple_cell (
    input  logic              i_clk,
    input  ple_pkg::t_cell_op i_op,
    input  ple_pkg::t_data    i_value,
    input  ple_pkg::t_data    i_lower,
    input  ple_pkg::t_data    i_upper,
    output ple_pkg::t_data    o_data
);

    ple_pkg::t_data r_data;
    ple_pkg::t_data n_data;

    always_comb begin
        case (i_op)
            ple_pkg::CELL_HOLD:       n_data = r_data;
            ple_pkg::CELL_LOAD:       n_data = i_value;
            ple_pkg::CELL_FROM_LOWER: n_data = i_lower;
            ple_pkg::CELL_FROM_UPPER: n_data = i_upper;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: rtl/positional_list_engine.sv
// Channel  | Handshake          | Fields
// ---------+--------------------+---------------------------------------------------
// request  | start, busy        | i_req_type, i_position, i_value_in
// result   | o_valid (strobe)   | o_status, o_value_out, o_count, o_cursor, o_has_next
//
// One request per cycle; its result strobes on the cycle after the accepting edge.
// A row of DEPTH cells shifts up or down on insert, append and remove.
// busy stays low: the cell row finishes every request in the accepting cycle.
// Synchronous active-low reset clears count, cursor and strobe; cell contents stay undefined.
// The receiver cannot stall; each result is present for exactly one cycle.
module positional_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [ple_pkg::CNT_W-1:0] i_position,
    input  logic [ple_pkg::WIDTH-1:0] i_value_in,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [ple_pkg::WIDTH-1:0] o_value_out,
    output logic [ple_pkg::CNT_W-1:0] o_count,
    output logic [ple_pkg::IDX_W-1:0] o_cursor,
    output logic        o_has_next
);

    ple_pkg::t_data    cell_data [ple_pkg::DEPTH];
    ple_pkg::t_cell_op cell_op   [ple_pkg::DEPTH];

    ple_pkg::t_count r_count;
    ple_pkg::t_count n_count;
    ple_pkg::t_index r_cursor;
    ple_pkg::t_index n_cursor;

    logic            accept;
    logic            full;
    logic            pos_le_cnt;
    logic            pos_lt_cnt;
    logic            write_ok;
    logic            read_ok;
    logic            remove_ok;
    ple_pkg::t_count wpos;
    ple_pkg::t_index pos_idx;
    ple_pkg::t_status status;
    ple_pkg::t_data  rd_data;
    logic [ple_pkg::CNT_W-1:0] cur_plus;

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign full       = (r_count >= ple_pkg::t_count'(ple_pkg::DEPTH));
    assign pos_le_cnt = (i_position <= r_count);
    assign pos_lt_cnt = (i_position < r_count);
    assign pos_idx    = i_position[ple_pkg::IDX_W-1:0];

    always_comb begin
        status    = ple_pkg::ST_OK;
        write_ok  = 1'b0;
        read_ok   = 1'b0;
        remove_ok = 1'b0;
        wpos      = i_position;
        case (i_req_type)
            ple_pkg::REQ_INSERT: begin
                if (!pos_le_cnt) begin
                    status = ple_pkg::ST_BADPOS;
                end else if (full) begin
                    status = ple_pkg::ST_FULL;
                end else begin
                    write_ok = 1'b1;
                end
            end
            ple_pkg::REQ_APPEND: begin
                wpos = r_count;
                if (full) begin
                    status = ple_pkg::ST_FULL;
                end else begin
                    write_ok = 1'b1;
                end
            end
            ple_pkg::REQ_READ: begin
                if (!pos_lt_cnt) begin
                    status = ple_pkg::ST_BADPOS;
                end else begin
                    read_ok = 1'b1;
                end
            end
            ple_pkg::REQ_REMOVE: begin
                if (!pos_lt_cnt) begin
                    status = ple_pkg::ST_BADPOS;
                end else begin
                    remove_ok = 1'b1;
                end
            end
            default: begin
                status = ple_pkg::ST_OK;
            end
        endcase
    end

    // steer each cell: load at the write slot, shift up above it, shift down on remove
    always_comb begin
        for (int i = 0; i < ple_pkg::DEPTH; i++) begin
            cell_op[i] = ple_pkg::CELL_HOLD;
            if (accept && write_ok) begin
                if (ple_pkg::t_count'(i) == wpos) begin
                    cell_op[i] = ple_pkg::CELL_LOAD;
                end else if (ple_pkg::t_count'(i) > wpos) begin
                    cell_op[i] = ple_pkg::CELL_FROM_LOWER;
                end
            end else if (accept && remove_ok) begin
                if (ple_pkg::t_count'(i) >= i_position) begin
                    cell_op[i] = ple_pkg::CELL_FROM_UPPER;
                end
            end
        end
    end

    for (genvar g = 0; g < ple_pkg::DEPTH; g++) begin : g_cell
        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op[g]),
            .i_value (i_value_in),
            .i_lower ((g == 0) ? '0 : cell_data[(g == 0) ? 0 : g - 1]),
            .i_upper ((g == ple_pkg::DEPTH - 1) ? '0
                      : cell_data[(g == ple_pkg::DEPTH - 1) ? g : g + 1]),
            .o_data  (cell_data[g])
        );
    end

    assign rd_data = read_ok ? cell_data[pos_idx] : '0;

    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        if (write_ok) begin
            n_count  = r_count + 1'b1;
            n_cursor = wpos[ple_pkg::IDX_W-1:0];
        end else if (read_ok) begin
            n_cursor = pos_idx;
        end else if (remove_ok) begin
            n_count = r_count - 1'b1;
            if (ple_pkg::t_count'(r_cursor) == i_position) begin
                n_cursor = '0;
            end else if (ple_pkg::t_count'(r_cursor) > i_position) begin
                n_cursor = r_cursor - 1'b1;
            end
        end else if (i_req_type == ple_pkg::REQ_CLEAR) begin
            n_count  = '0;
            n_cursor = '0;
        end
    end

    assign cur_plus = ple_pkg::t_count'(n_cursor) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= accept;
            if (accept) begin
                r_count  <= n_count;
                r_cursor <= n_cursor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_status    <= status;
            o_value_out <= rd_data;
            o_count     <= n_count;
            o_cursor    <= n_cursor;
            o_has_next  <= (cur_plus < n_count);
        end
    end

endmodule
